// File: rtl/bdq_pkg.sv
// shared types, constants and register codes of the biquad decimator
package bdq_pkg;

	localparam int MaxChannelsDef  = 8;
	localparam int FilterStagesDef = 4;
	localparam int CoefBitsDef     = 21;

	localparam int CfgAddrW = 3;
	localparam int CfgDataW = 63;

	localparam logic [31:0] DefaultSeed = 32'h6d2b_79f5;

	localparam logic [CfgAddrW-1:0] RegFactor   = 3'd0;
	localparam logic [CfgAddrW-1:0] RegChannels = 3'd1;
	localparam logic [CfgAddrW-1:0] RegSeed     = 3'd2;
	localparam logic [CfgAddrW-1:0] RegStage1   = 3'd3;
	localparam logic [CfgAddrW-1:0] RegStage2   = 3'd4;
	localparam logic [CfgAddrW-1:0] RegStage3   = 3'd5;
	localparam logic [CfgAddrW-1:0] RegStage4   = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILT,
		ST_QA,
		ST_QB,
		ST_QC
	} state_t;

	typedef struct packed {
		logic re;
		logic we;
		logic clr;
	} hist_ctl_t;

	typedef struct packed {
		logic load;
		logic dbl;
		logic neg;
		logic clr;
		logic add;
	} mac_ctl_t;

	typedef struct packed {
		logic first;
		logic second;
		logic seed_load;
	} dith_ctl_t;

endpackage

// File: rtl/biquad_decimator_dither_quantizer.sv
// top level: sequencer, stream state, configuration and output register
// sequence: accept in ST_IDLE; filtered words run the steps T_X to T_WR for each biquad stage
// on the single history memory and shared mac, then ST_QA, ST_QB, ST_QC; bypass (factor 1) goes to ST_QA
// a new input word is taken only in ST_IDLE; ST_QC holds while the output is full and m_tready is low
// one word in flight; a dropped frame still costs the full filter pass
// reset: async, clears control, coefficients and history valid bits; no clearing pass
module biquad_decimator_dither_quantizer #(
	parameter int MAX_CHANNELS  = bdq_pkg::MaxChannelsDef,
	parameter int FILTER_STAGES = bdq_pkg::FilterStagesDef,
	parameter int COEF_BITS     = bdq_pkg::CoefBitsDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [23:0]                   s_tdata,   // sample
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata,   // pcm_sample
	output logic [2:0]                    m_tuser,   // channel
	output logic                          m_tlast,   // frame_end
	input  logic                          cfg_en,
	input  logic [bdq_pkg::CfgAddrW-1:0]  cfg_addr,
	input  logic [bdq_pkg::CfgDataW-1:0]  cfg_data
);

	localparam int HD = FILTER_STAGES * MAX_CHANNELS * 4;
	localparam int AW = $clog2(HD);
	localparam int SW = (FILTER_STAGES > 1) ? $clog2(FILTER_STAGES) : 1;
	localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int PK = 3 * COEF_BITS;

	// steps of one biquad pass
	localparam logic [2:0] T_X  = 3'd0;  // x*b0, read x1
	localparam logic [2:0] T_X1 = 3'd1;  // 2*b0*x1, read x2
	localparam logic [2:0] T_X2 = 3'd2;  // b0*x2, read y1, store x2
	localparam logic [2:0] T_Y1 = 3'd3;  // -a1*y1, read y2, store x1
	localparam logic [2:0] T_Y2 = 3'd4;  // -a2*y2, store y2
	localparam logic [2:0] T_AC = 3'd5;  // last add
	localparam logic [2:0] T_WR = 3'd6;  // store y1, pass on

	bdq_pkg::state_t state_q, state_d;

	logic [5:0]        fac_q;
	logic [3:0]        chn_q;
	logic [31:0]       seed_q;
	logic [PK-1:0]     coef_q [FILTER_STAGES];

	logic [4:0]        phase_q;
	logic [2:0]        pos_q;
	logic [CW-1:0]     ch_q;
	logic              keep_q;
	logic              last_q;
	logic signed [31:0] x_q;
	logic signed [31:0] h0_q;
	logic signed [31:0] h2_q;
	logic [SW-1:0]     stg_q;
	logic [2:0]        step_q;

	logic [5:0]        eff_fac;
	logic [4:0]        eff_ch;
	logic              in_last;
	logic              accept;
	logic              restart;
	logic              out_load;
	logic              stg_end;

	bdq_pkg::hist_ctl_t hctl;
	bdq_pkg::mac_ctl_t  mctl;
	bdq_pkg::dith_ctl_t dctl;

	logic [AW-1:0]              raddr, waddr;
	logic signed [31:0]         wdata, rdata;
	logic signed [COEF_BITS-1:0] coef;
	logic signed [31:0]         mdata;
	logic signed [31:0]         y;
	logic signed [15:0]         q;
	logic [PK-1:0]              cur;

	// channel slot, wrapping the 3-bit position onto the memory rows
	function automatic logic [CW-1:0] chan_of(input logic [2:0] p);
		logic [4:0] r;
		r = 5'(p);
		for (int i = 0; i < 8; i++) begin
			if (r >= 5'(MAX_CHANNELS)) begin
				r = r - 5'(MAX_CHANNELS);
			end
		end
		return CW'(r);
	endfunction

	function automatic logic [AW-1:0] hist_addr(input logic [SW-1:0] s,
			input logic [CW-1:0] c, input logic [1:0] k);
		return AW'((int'(s) * MAX_CHANNELS + int'(c)) * 4 + int'(k));
	endfunction

	// out-of-range settings fold onto the nearest legal value
	assign eff_fac = (fac_q == 6'd0) ? 6'd1 : ((fac_q > 6'd32) ? 6'd32 : fac_q);
	assign eff_ch  = (chn_q == 4'd0) ? 5'd1 :
		((5'(chn_q) > 5'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS) : 5'(chn_q));
	assign in_last = (5'(pos_q) + 5'd1) >= eff_ch;

	assign s_tready = (state_q == bdq_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign restart  = cfg_en && (cfg_addr == bdq_pkg::RegFactor ||
		cfg_addr == bdq_pkg::RegChannels);
	assign stg_end  = (step_q == T_WR) && (stg_q == SW'(FILTER_STAGES - 1));
	assign cur      = coef_q[stg_q];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bdq_pkg::ST_IDLE: begin
				if (accept) begin
					if (eff_fac > 6'd1) begin
						state_d = bdq_pkg::ST_FILT;
					end else if (phase_q == 5'd0) begin
						state_d = bdq_pkg::ST_QA;
					end
				end
			end
			bdq_pkg::ST_FILT: begin
				if (stg_end) begin
					state_d = keep_q ? bdq_pkg::ST_QA : bdq_pkg::ST_IDLE;
				end
			end
			bdq_pkg::ST_QA: state_d = bdq_pkg::ST_QB;
			bdq_pkg::ST_QB: state_d = bdq_pkg::ST_QC;
			bdq_pkg::ST_QC: begin
				if (out_load) begin
					state_d = bdq_pkg::ST_IDLE;
				end
			end
			default: state_d = bdq_pkg::ST_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		hctl     = '0;
		mctl     = '0;
		dctl     = '0;
		raddr    = hist_addr(stg_q, ch_q, 2'd0);
		waddr    = hist_addr(stg_q, ch_q, 2'd0);
		wdata    = x_q;
		coef     = signed'(cur[COEF_BITS-1:0]);
		mdata    = rdata;
		out_load = 1'b0;
		hctl.clr = restart;
		dctl.seed_load = cfg_en && (cfg_addr == bdq_pkg::RegSeed);
		unique case (state_q)
			bdq_pkg::ST_FILT: begin
				mctl.add = (step_q != T_X) && (step_q != T_WR);
				mctl.clr = (step_q == T_X);
				case (step_q)
					T_X: begin
						hctl.re   = 1'b1;
						mctl.load = 1'b1;
						mdata     = x_q;
					end
					T_X1: begin
						hctl.re   = 1'b1;
						raddr     = hist_addr(stg_q, ch_q, 2'd1);
						mctl.load = 1'b1;
						mctl.dbl  = 1'b1;
					end
					T_X2: begin
						hctl.re   = 1'b1;
						raddr     = hist_addr(stg_q, ch_q, 2'd2);
						mctl.load = 1'b1;
						hctl.we   = 1'b1;
						waddr     = hist_addr(stg_q, ch_q, 2'd1);
						wdata     = h0_q;
					end
					T_Y1: begin
						hctl.re   = 1'b1;
						raddr     = hist_addr(stg_q, ch_q, 2'd3);
						mctl.load = 1'b1;
						mctl.neg  = 1'b1;
						coef      = signed'(cur[2*COEF_BITS-1:COEF_BITS]);
						hctl.we   = 1'b1;
					end
					T_Y2: begin
						mctl.load = 1'b1;
						mctl.neg  = 1'b1;
						coef      = signed'(cur[PK-1:2*COEF_BITS]);
						hctl.we   = 1'b1;
						waddr     = hist_addr(stg_q, ch_q, 2'd3);
						wdata     = h2_q;
					end
					T_WR: begin
						hctl.we   = 1'b1;
						waddr     = hist_addr(stg_q, ch_q, 2'd2);
						wdata     = y;
					end
					default: ;
				endcase
			end
			bdq_pkg::ST_QA: dctl.first  = 1'b1;
			bdq_pkg::ST_QB: dctl.second = 1'b1;
			bdq_pkg::ST_QC: out_load = !m_tvalid || m_tready;
			default: ;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fac_q  <= 6'd1;
			chn_q  <= 4'd1;
			seed_q <= 32'd0;
			for (int s = 0; s < FILTER_STAGES; s++) begin
				coef_q[s] <= '0;
			end
		end else if (cfg_en) begin
			unique case (cfg_addr)
				bdq_pkg::RegFactor:   fac_q  <= cfg_data[5:0];
				bdq_pkg::RegChannels: chn_q  <= cfg_data[3:0];
				bdq_pkg::RegSeed:     seed_q <= cfg_data[31:0];
				bdq_pkg::RegStage1, bdq_pkg::RegStage2,
				bdq_pkg::RegStage3, bdq_pkg::RegStage4: begin
					for (int s = 0; s < FILTER_STAGES; s++) begin
						if (int'(cfg_addr) - int'(bdq_pkg::RegStage1) == s) begin
							coef_q[s] <= cfg_data[PK-1:0];
						end
					end
				end
				default: ;
			endcase
		end
	end

	// stream position, sequencer counters and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= bdq_pkg::ST_IDLE;
			phase_q  <= 5'd0;
			pos_q    <= 3'd0;
			stg_q    <= '0;
			step_q   <= T_X;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (restart) begin
				phase_q <= 5'd0;
				pos_q   <= 3'd0;
			end else if (accept) begin
				if (in_last) begin
					pos_q   <= 3'd0;
					phase_q <= ((6'(phase_q) + 6'd1) >= eff_fac) ? 5'd0 : phase_q + 5'd1;
				end else begin
					pos_q <= pos_q + 3'd1;
				end
			end
			if (accept) begin
				stg_q  <= '0;
				step_q <= T_X;
			end else if (state_q == bdq_pkg::ST_FILT) begin
				if (step_q == T_WR) begin
					step_q <= T_X;
					stg_q  <= stg_q + SW'(1);
				end else begin
					step_q <= step_q + 3'd1;
				end
			end
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= {{3{s_tdata[23]}}, s_tdata, 5'd0};
			ch_q   <= chan_of(pos_q);
			keep_q <= (phase_q == 5'd0);
			last_q <= in_last;
		end else if (state_q == bdq_pkg::ST_FILT && step_q == T_WR) begin
			x_q <= y;
		end
		if (state_q == bdq_pkg::ST_FILT && step_q == T_X1) begin
			h0_q <= rdata;
		end
		if (state_q == bdq_pkg::ST_FILT && step_q == T_Y1) begin
			h2_q <= rdata;
		end
		if (out_load) begin
			m_tdata <= q;
			m_tuser <= 3'(ch_q);
			m_tlast <= last_q;
		end
	end

	bdq_hist_mem #(
		.DEPTH (HD),
		.AW    (AW)
	) u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (hctl),
		.raddr  (raddr),
		.waddr  (waddr),
		.wdata  (wdata),
		.rdata  (rdata)
	);

	bdq_mac #(
		.COEF_BITS (COEF_BITS)
	) u_mac (
		.clk  (clk),
		.ctl  (mctl),
		.coef (coef),
		.data (mdata),
		.y    (y)
	);

	bdq_dither u_dith (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (dctl),
		.seed   (cfg_data[31:0]),
		.y      (x_q),
		.q      (q)
	);

	// a history entry is never read and written in the same cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(hctl.re && hctl.we) |-> (raddr != waddr))
		else $error("history read and write hit one entry");

	// a filtered word always starts its pass at the first step of stage zero
	a_pass_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && eff_fac > 6'd1 && !cfg_en) |=>
		(state_q == bdq_pkg::ST_FILT && step_q == T_X && stg_q == '0))
		else $error("filter pass did not start cleanly");

	// step counter stays inside one biquad pass
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bdq_pkg::ST_FILT) |-> (step_q <= T_WR))
		else $error("step counter out of range");

	// channel position stays below the channel count in force
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(5'(pos_q) < eff_ch))
		else $error("channel position beyond channel count");

	// seed register is kept for reference of the last seed written
	a_seed_load: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_en && cfg_addr == bdq_pkg::RegSeed) |=> (seed_q == $past(cfg_data[31:0])))
		else $error("seed write lost");

endmodule

// File: rtl/bdq_hist_mem.sv
// filter history memory with per-entry valid bits
module bdq_hist_mem #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bdq_pkg::hist_ctl_t  ctl,
	input  logic [AW-1:0]       raddr,
	input  logic [AW-1:0]       waddr,
	input  logic signed [31:0]  wdata,
	output logic signed [31:0]  rdata
);

	logic signed [31:0] mem [DEPTH];
	logic [DEPTH-1:0]   vld_q;
	logic signed [31:0] rdata_q;
	logic               rvld_q;

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[waddr] <= wdata;
		end
		if (ctl.re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (ctl.re) begin
				rvld_q <= vld_q[raddr];
			end
			if (ctl.clr) begin
				vld_q <= '0;
			end else if (ctl.we) begin
				vld_q[waddr] <= 1'b1;
			end
		end
	end

	// never-written entries read as zero
	assign rdata = rvld_q ? rdata_q : 32'sd0;

endmodule

// File: rtl/bdq_mac.sv
// shared multiply-accumulate with rounding and saturation to q4.28
module bdq_mac #(
	parameter int COEF_BITS = 21
) (
	input  logic                        clk,
	input  bdq_pkg::mac_ctl_t           ctl,
	input  logic signed [COEF_BITS-1:0] coef,
	input  logic signed [31:0]          data,
	output logic signed [31:0]          y
);

	localparam int PW    = COEF_BITS + 34;
	localparam int ACC_W = COEF_BITS + 36;
	localparam int FRAC  = COEF_BITS - 2;
	localparam int SH_W  = ACC_W - FRAC;

	logic signed [COEF_BITS+31:0] prod;
	logic signed [PW-1:0]         term;
	logic signed [PW-1:0]         prod_s1;
	logic signed [ACC_W-1:0]      acc_q;
	logic signed [ACC_W-1:0]      rnd;
	logic signed [SH_W-1:0]       shf;
	logic [SH_W-32:0]             hi;

	assign prod = coef * data;

	always_comb begin
		term = PW'(prod);
		if (ctl.dbl) begin
			term = term <<< 1;
		end
		if (ctl.neg) begin
			term = -term;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			prod_s1 <= term;
		end
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.add) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end
	end

	// round half up then floor
	assign rnd = acc_q + (ACC_W'(1) <<< (FRAC - 1));
	assign shf = SH_W'(rnd >>> FRAC);
	assign hi  = shf[SH_W-1:31];

	always_comb begin
		if ((&hi) || !(|hi)) begin
			y = shf[31:0];
		end else if (shf[SH_W-1]) begin
			y = 32'sh8000_0000;
		end else begin
			y = 32'sh7fff_ffff;
		end
	end

endmodule

// File: rtl/bdq_dither.sv
// xorshift noise source, tpdf dither and 16-bit quantiser
module bdq_dither (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bdq_pkg::dith_ctl_t   ctl,
	input  logic [31:0]          seed,
	input  logic signed [31:0]   y,
	output logic signed [15:0]   q
);

	logic [31:0]        noise_q;
	logic [31:0]        nxt;
	logic [23:0]        u1_q;
	logic signed [29:0] c;
	logic signed [44:0] cs_s1;
	logic signed [45:0] v_s2;
	logic signed [25:0] dt;
	logic [45:0]        mag;
	logic [17:0]        rq;

	function automatic logic [31:0] xs32(input logic [31:0] s);
		logic [31:0] t;
		t = s ^ (s << 13);
		t = t ^ (t >> 17);
		t = t ^ (t << 5);
		return t;
	endfunction

	assign nxt = xs32(noise_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_q <= bdq_pkg::DefaultSeed;
		end else if (ctl.seed_load) begin
			noise_q <= (seed != 32'd0) ? seed : bdq_pkg::DefaultSeed;
		end else if (ctl.first || ctl.second) begin
			noise_q <= nxt;
		end
	end

	// clamp to +-1.0 in q4.28
	always_comb begin
		if (y > 32'sh1000_0000) begin
			c = 30'sh1000_0000;
		end else if (y < -32'sh1000_0000) begin
			c = -30'sh1000_0000;
		end else begin
			c = 30'(y);
		end
	end

	assign dt = signed'(26'(u1_q) + 26'(nxt[31:8]) - 26'h100_0000);

	always_ff @(posedge clk) begin
		if (ctl.first) begin
			u1_q  <= nxt[31:8];
			cs_s1 <= (45'(c) <<< 15) - 45'(c);
		end
		if (ctl.second) begin
			v_s2 <= 46'(cs_s1) + (46'(dt) <<< 4);
		end
	end

	// round half away from zero, saturate
	assign mag = v_s2[45] ? 46'(-v_s2) : 46'(v_s2);
	assign rq  = 18'((mag + 46'h800_0000) >> 28);

	always_comb begin
		if (v_s2[45]) begin
			q = (rq > 18'd32768) ? 16'sh8000 : 16'(-rq);
		end else begin
			q = (rq > 18'd32767) ? 16'sh7fff : 16'(rq);
		end
	end

endmodule
